[hdl/hsd_pkg.sv]
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types, constants and helpers for the static Huffman decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int LINK_W   = 10;
  localparam int LEAF_BIT = 9;

  // stream phase
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DECODE = 2'd1;
  localparam logic [1:0] PH_DRAIN  = 2'd2;

  typedef struct packed {
    logic [7:0] compressed_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] decoded_symbol;
    logic       run_last;
    logic       stream_done;
    logic       unsupported_header;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic hdr;
    logic clear;
    logic chk;
    logic rdb;
    logic sum;
    logic ins;
    logic root_ld;
    logic wiss;
    logic wstep;
    logic flush;
    logic flag;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] phase;
    logic       in_eof;
    logic       hdr_done;
    logic       single;
    logic       np_lt_nu;
    logic       ins_more;
    logic       leaf_wait;
    logic       step_end;
    logic       pv;
    logic       out_free;
    logic       eof_r;
  } stat_t;

  // child slot of pair wp: bit 0 -> 2p, bit 1 -> 2p-1
  function automatic logic [9:0] slot_of(logic [8:0] wp, logic b);
    logic [9:0] s2;
    s2 = {wp, 1'b0};
    if (s2 == 10'd0 && b) slot_of = 10'd0;
    else slot_of = s2 - {9'd0, b};
  endfunction

endpackage

[hdl/hsd_ctrl.sv]
// ----------------------------------------------------------------------------
// hsd_ctrl
// Sequencer for header intake, tree build and bit walk.
// ----------------------------------------------------------------------------
module hsd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hsd_pkg::stat_t stat,
  output hsd_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BCHK  = 4'd1;
  localparam logic [3:0] S_BRDB  = 4'd2;
  localparam logic [3:0] S_BSUM  = 4'd3;
  localparam logic [3:0] S_BINS  = 4'd4;
  localparam logic [3:0] S_BROOT = 4'd5;
  localparam logic [3:0] S_WISS  = 4'd6;
  localparam logic [3:0] S_WSTEP = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;
  localparam logic [3:0] S_FLAG  = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (stat.phase)
            hsd_pkg::PH_HEADER: begin
              cmd.hdr = 1'b1;
              if (stat.hdr_done && stat.single) state_nxt = S_FLAG;
              else if (stat.in_eof) cmd.clear = 1'b1;
              else if (stat.hdr_done) state_nxt = S_BCHK;
            end
            hsd_pkg::PH_DECODE: state_nxt = S_WISS;
            default: begin
              if (stat.in_eof) cmd.clear = 1'b1;
            end
          endcase
        end
      end
      S_BCHK: begin
        cmd.chk   = 1'b1;
        state_nxt = stat.np_lt_nu ? S_BRDB : S_BROOT;
      end
      S_BRDB: begin
        cmd.rdb   = 1'b1;
        state_nxt = S_BSUM;
      end
      S_BSUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_BINS;
      end
      S_BINS: begin
        cmd.ins = 1'b1;
        if (!stat.ins_more) state_nxt = S_BCHK;
      end
      S_BROOT: begin
        cmd.root_ld = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_WISS: begin
        cmd.wiss  = 1'b1;
        state_nxt = S_WSTEP;
      end
      S_WSTEP: begin
        if (!stat.leaf_wait) begin
          cmd.wstep = 1'b1;
          if (stat.step_end) state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pv || stat.out_free) begin
          cmd.flush = 1'b1;
          cmd.clear = stat.eof_r;
          state_nxt = S_IDLE;
        end
      end
      S_FLAG: begin
        if (stat.out_free) begin
          cmd.flag  = 1'b1;
          cmd.clear = stat.eof_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

[hdl/hsd_dpath.sv]
// ----------------------------------------------------------------------------
// hsd_dpath
// Header registers, node store, tree insertion and walk, output staging.
// ----------------------------------------------------------------------------
module hsd_dpath #(
  parameter int SYMBOLS     = 256,
  parameter int NODE_SLOTS  = 512,
  parameter int WEIGHT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hsd_pkg::in_item_t  in_data,
  input  hsd_pkg::cmd_t      cmd,
  output hsd_pkg::stat_t     stat,
  output logic               out_valid,
  input  logic               out_stall,
  output hsd_pkg::out_item_t out_data
);

  localparam int AW      = $clog2(NODE_SLOTS);
  localparam int EFF_MAX = (SYMBOLS < NODE_SLOTS / 2) ? SYMBOLS : NODE_SLOTS / 2;
  localparam int LW      = hsd_pkg::LINK_W;
  localparam int W       = WEIGHT_BITS;

  logic [LW-1:0] link_mem [NODE_SLOTS];
  logic [W-1:0]  wt_mem   [NODE_SLOTS];

  logic [1:0]    phase_r;
  logic [10:0]   hcnt_r;
  logic [2:0]    rcnt_r;
  logic [8:0]    kcnt_r;
  logic [31:0]   fs_r;
  logic [31:0]   exp_r;
  logic [8:0]    sym_r;
  logic [9:0]    nu_r, np_r, ins_r;
  logic [W-1:0]  wa_r, sum_r;
  logic [LW-1:0] slink_r;
  logic [8:0]    root_r, wp_r;
  logic [2:0]    bit_r;
  logic [7:0]    byte_r;
  logic          eof_r;
  logic [31:0]   emit_r;
  logic          pv_r, pdone_r;
  logic [7:0]    psym_r;
  logic [LW-1:0] rd_link_r;
  logic [W-1:0]  rd_wt_r;
  logic          oor_r;
  logic          out_valid_r;
  hsd_pkg::out_item_t out_data_r;

  logic [7:0]    b;
  logic          h_ge5, hdr_done, store;
  logic [10:0]   hcnt_inc, sym5;
  logic [8:0]    eff;
  logic [31:0]   fs_new;
  logic [W:0]    sum_full;
  logic [W-1:0]  sum_sat;
  logic          ins_more;
  logic [9:0]    npb;
  logic [LW-1:0] link_eff;
  logic          leaf, done, leaf_wait, step_end, out_free;
  logic [31:0]   emit_inc;
  logic [8:0]    wp_nxt;
  logic [2:0]    bit_dn;
  logic [9:0]    rd_slot, wr_slot;
  logic          rd_en, wl_en, ww_en;
  logic [LW-1:0] wl_data;
  logic [W-1:0]  ww_data;
  logic          step_push, flush_push, load;
  hsd_pkg::out_item_t load_data;

  assign b        = in_data.compressed_byte;
  assign h_ge5    = (hcnt_r >= 11'd5);
  assign hcnt_inc = hcnt_r + 11'd1;
  assign sym5     = {sym_r, 2'b00} + {2'b00, sym_r};
  assign hdr_done = h_ge5 && (hcnt_inc == sym5 + 11'd5);
  assign eff      = (sym_r > 9'(EFF_MAX)) ? 9'(EFF_MAX) : sym_r;
  assign store    = (kcnt_r < eff);
  assign fs_new   = (rcnt_r == 3'd1) ? {24'd0, b} : {fs_r[23:0], b};

  assign sum_full = {1'b0, wa_r} + {1'b0, rd_wt_r};
  assign sum_sat  = sum_full[W] ? {W{1'b1}} : sum_full[W-1:0];
  assign ins_more = (ins_r != 10'd0) && (rd_wt_r > sum_r);
  assign npb      = np_r + 10'd1;

  // slots past the store read as an empty link
  assign link_eff  = oor_r ? '0 : rd_link_r;
  assign leaf      = link_eff[hsd_pkg::LEAF_BIT];
  assign emit_inc  = emit_r + 32'd1;
  assign done      = (emit_inc == exp_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign leaf_wait = leaf && pv_r && !out_free;
  assign step_end  = (bit_r == 3'd0) || (leaf && done);
  assign wp_nxt    = leaf ? root_r : link_eff[8:0];
  assign bit_dn    = bit_r - 3'd1;

  always_comb begin
    rd_en   = 1'b1;
    rd_slot = 10'd0;
    priority if (cmd.chk)   rd_slot = (np_r < nu_r) ? np_r : nu_r;
    else if (cmd.rdb)       rd_slot = npb;
    else if (cmd.sum)       rd_slot = nu_r;
    else if (cmd.ins)       rd_slot = ins_r - 10'd1;
    else if (cmd.wiss)      rd_slot = hsd_pkg::slot_of(wp_r, byte_r[bit_r]);
    else if (cmd.wstep)     rd_slot = hsd_pkg::slot_of(wp_nxt, byte_r[bit_dn]);
    else                    rd_en   = 1'b0;
  end

  always_comb begin
    wl_en   = 1'b0;
    ww_en   = 1'b0;
    wr_slot = {1'b0, kcnt_r} + 10'd1;
    wl_data = {2'b10, b};
    ww_data = fs_new[W-1:0];
    if (cmd.hdr && h_ge5 && store) begin
      wl_en = (rcnt_r == 3'd0);
      ww_en = (rcnt_r == 3'd4);
    end else if (cmd.ins) begin
      wl_en   = 1'b1;
      ww_en   = 1'b1;
      wr_slot = ins_r + 10'd1;
      wl_data = ins_more ? rd_link_r : slink_r;
      ww_data = ins_more ? rd_wt_r : sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wl_en) link_mem[wr_slot[AW-1:0]] <= wl_data;
    if (ww_en) wt_mem[wr_slot[AW-1:0]] <= ww_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_link_r <= link_mem[rd_slot[AW-1:0]];
      rd_wt_r   <= wt_mem[rd_slot[AW-1:0]];
      oor_r     <= ({1'b0, rd_slot} >= 11'(NODE_SLOTS));
    end
  end

  assign step_push  = cmd.wstep && leaf && pv_r;
  assign flush_push = cmd.flush && pv_r;
  assign load       = step_push || flush_push || cmd.flag;

  always_comb begin
    if (cmd.flag) load_data = '{decoded_symbol: 8'd0, run_last: 1'b1,
                                stream_done: 1'b0, unsupported_header: 1'b1};
    else load_data = '{decoded_symbol: psym_r, run_last: flush_push,
                       stream_done: pdone_r, unsupported_header: 1'b0};
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= load_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= b;
      bit_r  <= 3'd7;
      eof_r  <= in_data.end_of_file;
    end
    if (cmd.rdb) wa_r <= rd_wt_r;
    if (cmd.sum) begin
      sum_r   <= sum_sat;
      slink_r <= {1'b0, npb[9:1]};
      ins_r   <= nu_r;
    end
    if (cmd.ins && ins_more) ins_r <= ins_r - 10'd1;
    if (cmd.root_ld) root_r <= rd_link_r[8:0];
    if (cmd.wstep) begin
      bit_r <= bit_dn;
      if (leaf) begin
        psym_r  <= link_eff[7:0];
        pdone_r <= done;
      end
    end
  end

  // stream state; end of file takes priority over the item's own update
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      phase_r <= hsd_pkg::PH_HEADER;
      hcnt_r  <= '0;
      rcnt_r  <= '0;
      kcnt_r  <= '0;
      fs_r    <= '0;
      exp_r   <= '0;
      sym_r   <= '0;
      nu_r    <= '0;
      np_r    <= 10'd1;
      wp_r    <= '0;
      emit_r  <= '0;
      pv_r    <= 1'b0;
    end else begin
      if (cmd.hdr) begin
        hcnt_r <= hcnt_inc;
        if (hcnt_r < 11'd4) exp_r <= {exp_r[23:0], b};
        else if (hcnt_r == 11'd4) sym_r <= (b == 8'd0) ? 9'd256 : {1'b0, b};
        else begin
          if (rcnt_r != 3'd0) fs_r <= fs_new;
          if (rcnt_r == 3'd4) begin
            rcnt_r <= 3'd0;
            kcnt_r <= kcnt_r + 9'd1;
          end else begin
            rcnt_r <= rcnt_r + 3'd1;
          end
        end
        if (hdr_done) begin
          nu_r <= {1'b0, eff};
          np_r <= 10'd1;
        end
      end
      if (cmd.sum) begin
        nu_r <= nu_r + 10'd1;
        np_r <= np_r + 10'd2;
      end
      if (cmd.root_ld) begin
        wp_r    <= rd_link_r[8:0];
        phase_r <= (exp_r != 32'd0) ? hsd_pkg::PH_DECODE : hsd_pkg::PH_DRAIN;
      end
      if (cmd.wstep) begin
        wp_r <= wp_nxt;
        if (leaf) begin
          emit_r <= emit_inc;
          pv_r   <= 1'b1;
          if (done) phase_r <= hsd_pkg::PH_DRAIN;
        end
      end
      if (cmd.flush) pv_r <= 1'b0;
      if (cmd.flag) phase_r <= hsd_pkg::PH_DRAIN;
    end
  end

  assign stat = '{phase: phase_r, in_eof: in_data.end_of_file, hdr_done: hdr_done,
                  single: (sym_r == 9'd1), np_lt_nu: (np_r < nu_r), ins_more: ins_more,
                  leaf_wait: leaf_wait, step_end: step_end, pv: pv_r,
                  out_free: out_free, eof_r: eof_r};

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/huffman_static_decoder.sv]
// ----------------------------------------------------------------------------
// huffman_static_decoder
// Static Huffman decoder for byte symbols, fed one compressed byte per item.
// ----------------------------------------------------------------------------
// Header bytes are taken without stalling. When the header completes, the tree is
// rebuilt over the node store, which has one read and one write port: per pair a
// check, a weight read, a sum and a sorted insertion that repeats per entry it
// shifts, then a check and a root fetch; no item is taken meanwhile. A header of
// a single symbol raises the flag instead. A code byte is accepted, the walk is
// started, the store is read once per code bit up to the last symbol and the byte
// is closed, waiting while the output stage is stalled; drain-phase bytes do not stall.
module huffman_static_decoder #(
  parameter int SYMBOLS     = 256,
  parameter int NODE_SLOTS  = 512,
  parameter int WEIGHT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hsd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hsd_pkg::out_item_t out_data
);

  hsd_pkg::cmd_t  cmd;
  hsd_pkg::stat_t stat;

  hsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  hsd_dpath #(
    .SYMBOLS     (SYMBOLS),
    .NODE_SLOTS  (NODE_SLOTS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // a code byte always goes through the walk
  a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && stat.phase == hsd_pkg::PH_DECODE) |=> in_stall)
    else $error("code item accepted without walk");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.stream_done) |-> out_data.run_last)
    else $error("stream end not last of item");

  a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.unsupported_header) |->
      (out_data.decoded_symbol == 8'd0 && !out_data.stream_done))
    else $error("flag result carries a symbol");
`endif

endmodule

[bench/tb_huffman_static_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_huffman_static_decoder
// Feeds whole compressed files (header, code bytes, trailing bytes) through the
// decoder and checks every decoded symbol and flag against an in-bench model.
// ----------------------------------------------------------------------------
module tb_huffman_static_decoder;

  localparam int NSLOT     = 512;
  localparam int NSYM      = 256;
  localparam int LEAF      = 10'h200;
  localparam int STALL_MAX = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  hsd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  hsd_pkg::out_item_t out_data;

  huffman_static_decoder uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // decoder model state
  logic [9:0]  tree_link[NSLOT];
  logic [31:0] tree_weight[NSLOT];
  logic [1:0]  dec_phase;
  int unsigned hdr_count, shift_acc, orig_len, sym_total, node_total, pair_idx;
  int unsigned walk_pair, sym_emitted;

  hsd_pkg::out_item_t symbols_due[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        idle_cycles = 0;
  bit        gaps_on = 1'b0;

  function automatic int unsigned eff_syms();
    return sym_total > NSYM ? NSYM : sym_total;
  endfunction

  function automatic logic [9:0] link_of(int unsigned s);
    return s < NSLOT ? tree_link[s] : 10'd0;
  endfunction

  function automatic void restart_stream();
    dec_phase = hsd_pkg::PH_HEADER;
    hdr_count = 0; shift_acc = 0; orig_len = 0; sym_total = 0;
    node_total = 0; pair_idx = 1; walk_pair = 0; sym_emitted = 0;
  endfunction

  function automatic void place_node(int unsigned lnk, logic [31:0] w);
    int unsigned i;
    i = node_total;
    node_total = (node_total + 1) & 10'h3FF;
    while (i > 0 && i + 1 < NSLOT && tree_weight[i] > w) begin
      tree_link[i+1] = tree_link[i];
      tree_weight[i+1] = tree_weight[i];
      i--;
    end
    i++;
    if (i < NSLOT) begin
      tree_link[i] = lnk[9:0];
      tree_weight[i] = w;
    end
  endfunction

  function automatic void grow_tree();
    logic [32:0] s;
    node_total = eff_syms();
    pair_idx = 1;
    while (pair_idx < node_total && pair_idx + 1 < NSLOT) begin
      s = tree_weight[pair_idx] + tree_weight[pair_idx+1];
      if (s[32]) s = 33'hFFFF_FFFF;
      place_node((pair_idx + 1) / 2, s[31:0]);
      pair_idx += 2;
    end
    walk_pair = {23'd0, link_of(node_total) & 10'h1FF};
  endfunction

  // works out the symbols one accepted byte yields and queues them
  function automatic void decode_byte(logic [7:0] b, logic eof);
    hsd_pkg::out_item_t res[$];
    hsd_pkg::out_item_t r;
    int unsigned h, k, rr, slot;
    logic [9:0]  lnk;
    if (dec_phase == hsd_pkg::PH_HEADER) begin
      h = hdr_count;
      if (h < 4) orig_len = (orig_len << 8) | b;
      else if (h == 4) sym_total = (b == 0) ? 256 : b;
      else begin
        k = (h - 5) / 5; rr = (h - 5) % 5;
        if (rr == 0) begin
          if (k < eff_syms()) tree_link[k+1] = 10'(LEAF | b);
        end else begin
          shift_acc = (rr == 1) ? b : ((shift_acc << 8) | b);
          if (rr == 4 && k < eff_syms()) tree_weight[k+1] = shift_acc;
        end
      end
      hdr_count = (h + 1) & 11'h7FF;
      if (h >= 5 && hdr_count == 5 + 5 * sym_total) begin
        if (sym_total == 1) begin
          r = '0; r.unsupported_header = 1'b1;
          res.push_back(r);
          dec_phase = hsd_pkg::PH_DRAIN;
        end else begin
          grow_tree();
          dec_phase = orig_len != 0 ? hsd_pkg::PH_DECODE : hsd_pkg::PH_DRAIN;
        end
      end
    end else if (dec_phase == hsd_pkg::PH_DECODE) begin
      for (int i = 7; i >= 0; i--) begin
        slot = 2 * walk_pair - b[i];
        if (2 * walk_pair < b[i]) slot = 0;
        lnk = link_of(slot);
        if (lnk[9]) begin
          sym_emitted++;
          r = '0;
          r.decoded_symbol = lnk[7:0];
          r.stream_done = (sym_emitted == orig_len);
          res.push_back(r);
          if (r.stream_done) begin
            dec_phase = hsd_pkg::PH_DRAIN;
            break;
          end
          walk_pair = {23'd0, link_of(node_total) & 10'h1FF};
        end else begin
          walk_pair = {23'd0, lnk & 10'h1FF};
        end
      end
    end
    if (eof) restart_stream();
    if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    foreach (res[j]) symbols_due.push_back(res[j]);
  endfunction

  // one input item; valid stays high afterwards unless the next call gaps
  task automatic send_byte(logic [7:0] b, logic eof);
    while (gaps_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{compressed_byte: b, end_of_file: eof};
    do @(posedge clk); while (in_stall);
    items_sent++;
    decode_byte(b, eof);
  endtask

  // header then code bytes; cut > 0 ends the file on that code byte
  task automatic send_file(int nsym, int unsigned len, bit heavy, int cut, bit trunc);
    logic [31:0] w;
    int          hdr_len, n, guard;
    logic [7:0]  hdr[$];
    w = heavy ? 32'hFFFF_FFF0 : $urandom_range(3);
    for (int i = 3; i >= 0; i--) hdr.push_back(8'(len >> (8 * i)));
    hdr.push_back(nsym[7:0]);
    for (int s = 0; s < nsym; s++) begin
      hdr.push_back(8'($urandom_range(255)));
      for (int i = 3; i >= 0; i--) hdr.push_back(8'(w >> (8 * i)));
      if (heavy) begin
        if (w != 32'hFFFF_FFFF) w += $urandom_range(1);
      end else w += $urandom_range(5);
    end
    if (trunc) begin
      hdr_len = $urandom_range(hdr.size() - 2, 1);
      for (int i = 0; i < hdr_len; i++) send_byte(hdr[i], i == hdr_len - 1);
      return;
    end
    foreach (hdr[i]) send_byte(hdr[i], 1'b0);
    n = 0; guard = 0;
    while (dec_phase == hsd_pkg::PH_DECODE && guard < 300) begin
      n++; guard++;
      send_byte(8'($urandom_range(255)), n == cut);
      if (n == cut) return;
    end
    n = $urandom_range(3);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic test_plain_file();
    send_file(2, 5, 0, 0, 0);
    send_file(3, 4, 0, 0, 0);
  endtask

  // count byte zero announces 256 records; the file ends a few records in
  task automatic test_full_alphabet();
    for (int i = 0; i < 4; i++) send_byte((i == 3) ? 8'd12 : 8'd0, 1'b0);
    send_byte(8'd0, 1'b0);
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(255)), i == 19);
  endtask

  task automatic test_single_symbol();
    send_file(1, 7, 0, 0, 0);
  endtask

  task automatic test_zero_length();
    send_file(3, 0, 0, 0, 0);
  endtask

  task automatic test_weight_saturation();
    send_file(5, 9, 1, 0, 0);
  endtask

  task automatic test_truncated_header();
    send_file(2, 3, 0, 0, 1);
  endtask

  task automatic test_abort_mid_decode();
    send_file(4, 200, 0, 2, 0);
  endtask

  task automatic test_random_files();
    int target;
    target = items_sent + 60;
    while (items_sent < target) begin
      case ($urandom_range(19))
        0: send_file(1, $urandom_range(9), 0, 0, 0);
        1: send_file($urandom_range(8, 2), $urandom_range(9), 0, 0, 1);
        2: send_file($urandom_range(8, 2), 0, 0, 0, 0);
        3: send_file($urandom_range(8, 2), 50, $urandom_range(1), $urandom_range(3, 1), 0);
        default: send_file($urandom_range(8, 2), $urandom_range(20, 1),
                           $urandom_range(9) == 0, 0, 0);
      endcase
    end
  endtask

  // result checker
  always @(posedge clk) begin
    hsd_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (symbols_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected symbol item: %p", out_data);
      end else begin
        want = symbols_due.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk)
    out_stall <= gaps_on && ($urandom_range(99) < 17);

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("tb_huffman_static_decoder: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tree_link[i] = '0;
      tree_weight[i] = '0;
    end
    restart_stream();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // first stretch runs without gaps
    test_plain_file();
    test_full_alphabet();
    test_single_symbol();
    gaps_on = 1'b1;
    test_zero_length();
    test_weight_saturation();
    test_truncated_header();
    test_abort_mid_decode();
    test_random_files();
    in_valid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && symbols_due.size() == 0)
      $display("tb_huffman_static_decoder: clean");
    else
      $display("tb_huffman_static_decoder: errors");
    $finish;
  end

endmodule
